[sv/pixel_color_effect_assert.svh]
// Assertion macros used by the pixel color effect top module.
`ifndef PIXEL_COLOR_EFFECT_ASSERT_SVH
`define PIXEL_COLOR_EFFECT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PCE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PCE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/pce_pkg.sv]
package pce_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned CoefW = 16;
  localparam int unsigned SepiaShift = 16;
  // Widest sepia sum: (25756 + 50397 + 12386) * 255 < 2**25.
  localparam int unsigned SepiaAccW = 25;
  // Value range after the shift or the ice scaling, before clipping.
  localparam int unsigned WideW = 9;
  localparam int unsigned IceSumW = 9;
  localparam int unsigned IceProdW = 11;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  // Configuration port.
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] CfgIdxMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxOrder = 2'd1;

  typedef enum logic [1:0] {
    ModePass  = 2'd0,
    ModeSepia = 2'd1,
    ModeIce   = 2'd2
  } mode_e;

  // Mode code with no meaning: a write of it leaves the mode unchanged.
  localparam logic [1:0] ModeCodeRsv = 2'd3;

  typedef logic [ChanW-1:0] chan_t;

  // Sepia matrix, unsigned Q0.16, rows give R', G', B' from R, G, B.
  localparam logic [CoefW-1:0] SepiaCoef [NumChan][NumChan] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

  function automatic chan_t sat_chan(input logic [WideW-1:0] v);
    sat_chan = (v > WideW'(ChanMax)) ? ChanMax : v[ChanW-1:0];
  endfunction

endpackage

[sv/pixel_color_effect.sv]
// Pixel color effect: recolors one 3-channel 8-bit pixel per beat.
//
// Input channel: drive chan_first_i/chan_second_i/chan_third_i with start
// high; a beat is taken at each rising edge where start is high and busy is
// low. busy stays low, so a new pixel may be offered every cycle.
// Result channel: out_valid_o marks the recolored pixel on out_*_o for
// exactly one cycle. The receiver cannot stall; it must take each beat.
// Path: an accepted pixel passes the input register, then the result
// register. Throughput: one pixel per clock, set by the single compute
// stage between those two registers.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i, cfg_data_i.
// Index 0 is effect_mode (0 pass, 1 sepia, 2 ice; code 3 is dropped),
// index 1 is order_is_rgb. Other indexes are dropped. cfg_ready_o is
// always high. Write only while no pixel is in flight.
// Reset (rst_ni low, asynchronous): mode pass-through, RGB order, no
// pixel in flight.
`include "pixel_color_effect_assert.svh"

module pixel_color_effect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  pce_pkg::chan_t                chan_first_i,
  input  pce_pkg::chan_t                chan_second_i,
  input  pce_pkg::chan_t                chan_third_i,
  output logic                          out_valid_o,
  output pce_pkg::chan_t                out_first_o,
  output pce_pkg::chan_t                out_second_o,
  output pce_pkg::chan_t                out_third_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pce_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pce_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pce_pkg::*;

  mode_e  mode_q;
  logic   order_is_rgb_q;
  logic   cfg_we;

  logic   accept;
  logic   in_vld_q;
  chan_t  in_q    [NumChan];
  chan_t  sepia   [NumChan];
  chan_t  ice     [NumChan];
  chan_t  res_d   [NumChan];
  chan_t  res_q   [NumChan];
  logic   res_vld_q;

  // Every beat is taken; the pipeline never backs up.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Configuration registers. Drop the meaningless mode code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= ModePass;
      order_is_rgb_q <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index_i == CfgIdxMode && cfg_data_i[1:0] != ModeCodeRsv) begin
        mode_q <= mode_e'(cfg_data_i[1:0]);
      end
      if (cfg_index_i == CfgIdxOrder) begin
        order_is_rgb_q <= cfg_data_i[0];
      end
    end
  end

  // Input register: capture the pixel on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q[0] <= chan_first_i;
      in_q[1] <= chan_second_i;
      in_q[2] <= chan_third_i;
    end
  end

  pce_sepia u_sepia (
    .order_is_rgb_i (order_is_rgb_q),
    .chan_i         (in_q),
    .chan_o         (sepia)
  );

  pce_ice u_ice (
    .chan_i (in_q),
    .chan_o (ice)
  );

  // Pick the effect for the registered pixel.
  always_comb begin
    case (mode_q)
      ModePass:  res_d = in_q;
      ModeSepia: res_d = sepia;
      ModeIce:   res_d = ice;
      default:   res_d = in_q;
    endcase
  end

  // Result register: hold the pixel for its one strobe cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = res_vld_q;
  assign out_first_o  = res_q[0];
  assign out_second_o = res_q[1];
  assign out_third_o  = res_q[2];

  // An accepted beat always yields exactly one result, through the input and result registers.
  `PCE_ASSERT(a_accept_to_result, accept |=> ##1 out_valid_o, "accepted pixel lost")
  `PCE_ASSERT(a_result_has_source, out_valid_o |-> $past(in_vld_q), "result without pixel")
  // Pass-through must copy the registered pixel unchanged.
  `PCE_ASSERT(a_pass_copies, (in_vld_q && mode_q == ModePass) |=>
    (out_first_o == $past(in_q[0]) && out_second_o == $past(in_q[1])
     && out_third_o == $past(in_q[2])), "pass-through altered pixel")
  `PCE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "strobe during reset")

endmodule

[sv/pce_sepia.sv]
module pce_sepia (
  input  logic            order_is_rgb_i,
  input  pce_pkg::chan_t  chan_i [pce_pkg::NumChan],
  output pce_pkg::chan_t  chan_o [pce_pkg::NumChan]
);
  import pce_pkg::*;

  chan_t                  rgb    [NumChan];
  logic [SepiaAccW-1:0]   acc    [NumChan];
  chan_t                  res    [NumChan];

  // Map the pixel to R, G, B order.
  assign rgb[0] = order_is_rgb_i ? chan_i[0] : chan_i[2];
  assign rgb[1] = chan_i[1];
  assign rgb[2] = order_is_rgb_i ? chan_i[2] : chan_i[0];

  for (genvar row = 0; row < NumChan; row++) begin : g_row
    assign acc[row] = SepiaAccW'(SepiaCoef[row][0]) * SepiaAccW'(rgb[0])
                    + SepiaAccW'(SepiaCoef[row][1]) * SepiaAccW'(rgb[1])
                    + SepiaAccW'(SepiaCoef[row][2]) * SepiaAccW'(rgb[2]);
    assign res[row] = sat_chan(acc[row][SepiaAccW-1:SepiaShift]);
  end

  // Map back to the pixel's own channel order.
  assign chan_o[0] = order_is_rgb_i ? res[0] : res[2];
  assign chan_o[1] = res[1];
  assign chan_o[2] = order_is_rgb_i ? res[2] : res[0];

endmodule

[sv/pce_ice.sv]
module pce_ice (
  input  pce_pkg::chan_t  chan_i [pce_pkg::NumChan],
  output pce_pkg::chan_t  chan_o [pce_pkg::NumChan]
);
  import pce_pkg::*;

  logic [IceSumW-1:0]  others [NumChan];
  logic [IceSumW-1:0]  own    [NumChan];
  logic [IceSumW-1:0]  diff   [NumChan];
  logic [IceProdW-1:0] prod   [NumChan];

  assign others[0] = IceSumW'(chan_i[1]) + IceSumW'(chan_i[2]);
  assign others[1] = IceSumW'(chan_i[0]) + IceSumW'(chan_i[2]);
  assign others[2] = IceSumW'(chan_i[0]) + IceSumW'(chan_i[1]);

  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    assign own[c]  = IceSumW'(chan_i[c]);
    assign diff[c] = (own[c] >= others[c]) ? own[c] - others[c] : others[c] - own[c];
    // Scale by 3/4: 2d + d, then drop two bits.
    assign prod[c] = IceProdW'({diff[c], 1'b0}) + IceProdW'(diff[c]);
    assign chan_o[c] = sat_chan(prod[c][IceProdW-1:2]);
  end

endmodule
